[rtl/core/idc_pkg.sv]
// Shared types, constants and helper functions for the inclinometer display controller.
// Has no dependencies; every other file in rtl/core uses it through scoped names.

package idc_pkg;

    localparam int ANGLE_W   = 16;
    localparam int TICK_W    = 16;
    localparam int SEG_W     = 8;
    localparam int HOLD_W    = 18;
    localparam int DISP_W    = 19;
    localparam int MAG_W     = 17;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 16;
    localparam int IN_DAT_W  = 40;
    localparam int OUT_DAT_W = 48;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_STORED_OFFSET = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STORED_VALID  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLINK_PERIOD  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REARM_DELAY   = 4'd3;

    localparam logic [TICK_W-1:0] BLINK_PERIOD_RST = 16'd250;
    localparam logic [TICK_W-1:0] REARM_DELAY_RST  = 16'd1000;

    // Active-low glyphs, bit order dp g f e d c b a.
    localparam logic [SEG_W-1:0] SEG_MINUS = 8'hFB;
    localparam logic [SEG_W-1:0] SEG_PLUS  = 8'hF3;
    localparam logic [SEG_W-1:0] SEG_DP    = 8'h7F;
    localparam logic [SEG_W-1:0] SEG_BLANK = 8'hFF;
    localparam logic [SEG_W-1:0] SEG_NINE  = 8'h98;

    // Range limits of the magnitude in hundredths of a degree.
    localparam logic [MAG_W-1:0] MAG_FINE_LIMIT   = 17'd1000;
    localparam logic [MAG_W-1:0] MAG_COARSE_LIMIT = 17'd9000;

    typedef struct packed {
        logic                     calibrate_level;
        logic                     hold_level;
        logic [TICK_W-1:0]        now;
        logic signed [ANGLE_W-1:0] angle;
        logic                     sensor_ok;
    } item_t;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] saved_offset;
        logic                     save_strobe;
        logic                     cal_led;
        logic [SEG_W-1:0]         seg_sign;
        logic [SEG_W-1:0]         seg_high;
        logic [SEG_W-1:0]         seg_low;
    } res_t;

    function automatic logic [SEG_W-1:0] seg_font(input logic [3:0] digit);
        logic [SEG_W-1:0] pat;
        case (digit)
            4'd0:    pat = 8'hC0;
            4'd1:    pat = 8'hF9;
            4'd2:    pat = 8'hA4;
            4'd3:    pat = 8'hB0;
            4'd4:    pat = 8'h99;
            4'd5:    pat = 8'h92;
            4'd6:    pat = 8'h82;
            4'd7:    pat = 8'hF8;
            4'd8:    pat = 8'h80;
            4'd9:    pat = 8'h98;
            default: pat = SEG_BLANK;
        endcase
        return pat;
    endfunction

    // Division by ten for values below 128, by reciprocal multiplication.
    function automatic logic [3:0] div10(input logic [6:0] x);
        logic [14:0] prod;
        prod = 15'(x) * 15'd205;
        return prod[14:11];
    endfunction

    // True when the wrapped distance from mark to now exceeds limit.
    function automatic logic elapsed(input logic [TICK_W-1:0] now,
                                     input logic [TICK_W-1:0] mark,
                                     input logic [TICK_W-1:0] limit);
        logic [TICK_W-1:0] diff;
        diff = now - mark;
        return diff > limit;
    endfunction

endpackage

[rtl/core/idc_in_stage.sv]
// Input register of the inclinometer display controller: holds one request
// until the control stage takes it. Depends on idc_pkg.

module idc_in_stage
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [idc_pkg::IN_DAT_W-1:0]      s_tdata,
    input  logic                              advance,
    output logic                              in_valid,
    output idc_pkg::item_t                    item
);

    logic           valid_reg;
    logic           valid_next;
    idc_pkg::item_t item_reg;

    assign s_tready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_tready)
        begin
            valid_next = s_tvalid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            item_reg <= s_tdata[$bits(idc_pkg::item_t)-1:0];
        end
    end

    assign in_valid = valid_reg;
    assign item     = item_reg;

endmodule

[rtl/core/idc_digits.sv]
// Auto-ranging of a tilt magnitude onto the two numeric seven-segment digits.
// Pure combinational logic; depends on idc_pkg for the font and constants.

module idc_digits
(
    input  logic [idc_pkg::MAG_W-1:0] mag,
    output logic [idc_pkg::SEG_W-1:0] seg_low,
    output logic [idc_pkg::SEG_W-1:0] seg_high
);

    logic [26:0] q_prod;
    logic [6:0]  q100;
    logic [9:0]  r_full;
    logic [6:0]  r100;
    logic [3:0]  tenths;
    logic [3:0]  tens;
    logic [3:0]  units;

    // Below 9000 the quotient by 100 is exact with this reciprocal.
    assign q_prod = 27'(mag[13:0]) * 27'd5243;
    assign q100   = q_prod[25:19];
    assign r_full = mag[9:0] - 10'(q100) * 10'd100;
    assign r100   = r_full[6:0];
    assign tenths = idc_pkg::div10(r100);
    assign tens   = idc_pkg::div10(q100);
    assign units  = q100[3:0] - tens * 4'd10;

    always_comb
    begin
        if (mag < idc_pkg::MAG_FINE_LIMIT)
        begin
            seg_low  = idc_pkg::seg_font(tenths);
            seg_high = idc_pkg::seg_font(q100[3:0]) & idc_pkg::SEG_DP;
        end
        else if (mag < idc_pkg::MAG_COARSE_LIMIT)
        begin
            seg_low  = idc_pkg::seg_font(units);
            seg_high = idc_pkg::seg_font(tens);
        end
        else
        begin
            seg_low  = idc_pkg::SEG_BLANK;
            seg_high = idc_pkg::SEG_BLANK;
        end
    end

endmodule

[rtl/core/idc_ctrl.sv]
// Control stage: configuration registers, mode, offsets, debouncer, blink
// timing and the digit registers. Depends on idc_pkg and idc_digits.

module idc_ctrl
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               step,
    input  idc_pkg::item_t                     item,
    input  logic                               cfg_valid,
    input  logic [idc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [idc_pkg::CFG_DAT_W-1:0]      cfg_data,
    output idc_pkg::res_t                      result
);

    logic signed [idc_pkg::ANGLE_W-1:0] stored_offset_reg, stored_offset_next;
    logic                               stored_valid_reg, stored_valid_next;
    logic [idc_pkg::TICK_W-1:0]         blink_period_reg, blink_period_next;
    logic [idc_pkg::TICK_W-1:0]         rearm_delay_reg, rearm_delay_next;

    logic                               calibrating_reg, calibrating_next;
    logic signed [idc_pkg::ANGLE_W-1:0] cal_offset_reg, cal_offset_next;
    logic                               is_cal_reg, is_cal_next;
    logic signed [idc_pkg::HOLD_W-1:0]  hold_offset_reg, hold_offset_next;
    logic [idc_pkg::TICK_W-1:0]         blink_mark_reg, blink_mark_next;
    logic                               led_reg, led_next;
    logic [idc_pkg::SEG_W-1:0]          err_glyph_reg, err_glyph_next;
    logic                               inhibit_reg, inhibit_next;
    logic                               rel_timing_reg, rel_timing_next;
    logic [idc_pkg::TICK_W-1:0]         rel_mark_reg, rel_mark_next;
    logic [idc_pkg::SEG_W-1:0]          dig_low_reg, dig_low_next;
    logic [idc_pkg::SEG_W-1:0]          dig_high_reg, dig_high_next;
    logic [idc_pkg::SEG_W-1:0]          dig_sign_reg, dig_sign_next;

    logic signed [idc_pkg::DISP_W-1:0]  disp;
    logic signed [idc_pkg::DISP_W-1:0]  disp_abs;
    logic                               positive;
    logic [idc_pkg::SEG_W-1:0]          num_low;
    logic [idc_pkg::SEG_W-1:0]          num_high;
    logic                               press;
    logic                               strobe;
    logic [idc_pkg::SEG_W-1:0]          glyph_flip;

    assign disp = idc_pkg::DISP_W'(item.angle) - idc_pkg::DISP_W'(cal_offset_reg)
                - idc_pkg::DISP_W'(hold_offset_reg);
    assign positive = !disp[idc_pkg::DISP_W-1];
    assign disp_abs = positive ? disp : -disp;

    idc_digits u_digits
    (
        .mag      (disp_abs[idc_pkg::MAG_W-1:0]),
        .seg_low  (num_low),
        .seg_high (num_high)
    );

    // Hold button debouncer: a press is reported once, and re-arms only when the
    // button is seen released longer than the rearm delay after its first release.
    always_comb
    begin
        press           = 1'b0;
        inhibit_next    = inhibit_reg;
        rel_timing_next = rel_timing_reg;
        rel_mark_next   = rel_mark_reg;
        if (step && item.sensor_ok)
        begin
            if (!inhibit_reg)
            begin
                if (item.hold_level)
                begin
                    inhibit_next = 1'b1;
                    press        = 1'b1;
                end
            end
            else if (!item.hold_level)
            begin
                if (rel_timing_reg)
                begin
                    if (idc_pkg::elapsed(item.now, rel_mark_reg, rearm_delay_reg))
                    begin
                        inhibit_next    = 1'b0;
                        rel_timing_next = 1'b0;
                    end
                end
                else
                begin
                    rel_timing_next = 1'b1;
                    rel_mark_next   = item.now;
                end
            end
        end
    end

    assign glyph_flip = (err_glyph_reg == idc_pkg::SEG_BLANK) ? idc_pkg::SEG_NINE
                                                             : idc_pkg::SEG_BLANK;

    always_comb
    begin
        stored_offset_next = stored_offset_reg;
        stored_valid_next  = stored_valid_reg;
        blink_period_next  = blink_period_reg;
        rearm_delay_next   = rearm_delay_reg;
        calibrating_next   = calibrating_reg;
        cal_offset_next    = cal_offset_reg;
        is_cal_next        = is_cal_reg;
        hold_offset_next   = hold_offset_reg;
        blink_mark_next    = blink_mark_reg;
        led_next           = led_reg;
        err_glyph_next     = err_glyph_reg;
        dig_low_next       = dig_low_reg;
        dig_high_next      = dig_high_reg;
        dig_sign_next      = dig_sign_reg;
        strobe             = 1'b0;

        if (step)
        begin
            if (item.sensor_ok)
            begin
                dig_low_next  = num_low;
                dig_high_next = num_high;
                dig_sign_next = positive ? idc_pkg::SEG_PLUS : idc_pkg::SEG_MINUS;
                if (calibrating_reg)
                begin
                    led_next = 1'b1;
                    if (press)
                    begin
                        cal_offset_next  = item.angle;
                        hold_offset_next = '0;
                        strobe           = 1'b1;
                        is_cal_next      = 1'b1;
                        led_next         = 1'b0;
                        calibrating_next = 1'b0;
                    end
                end
                else
                begin
                    if (press)
                    begin
                        hold_offset_next = hold_offset_reg + disp[idc_pkg::HOLD_W-1:0];
                    end
                    else if (item.calibrate_level)
                    begin
                        calibrating_next = 1'b1;
                    end
                    if (!is_cal_reg
                        && idc_pkg::elapsed(item.now, blink_mark_reg, blink_period_reg))
                    begin
                        led_next        = !led_reg;
                        blink_mark_next = item.now;
                    end
                end
            end
            else if (idc_pkg::elapsed(item.now, blink_mark_reg, blink_period_reg))
            begin
                err_glyph_next  = glyph_flip;
                dig_low_next    = glyph_flip;
                dig_high_next   = glyph_flip;
                blink_mark_next = item.now;
            end
        end
        else if (cfg_valid)
        begin
            // Writing either store register reloads the calibration as at power-up.
            case (cfg_index)
                idc_pkg::REG_STORED_OFFSET:
                begin
                    stored_offset_next = cfg_data;
                    cal_offset_next    = stored_valid_reg ? cfg_data : '0;
                    is_cal_next        = stored_valid_reg;
                end
                idc_pkg::REG_STORED_VALID:
                begin
                    stored_valid_next = cfg_data[0];
                    cal_offset_next   = cfg_data[0] ? stored_offset_reg : '0;
                    is_cal_next       = cfg_data[0];
                end
                idc_pkg::REG_BLINK_PERIOD: blink_period_next = cfg_data;
                idc_pkg::REG_REARM_DELAY:  rearm_delay_next  = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stored_offset_reg <= '0;
            stored_valid_reg  <= 1'b0;
            blink_period_reg  <= idc_pkg::BLINK_PERIOD_RST;
            rearm_delay_reg   <= idc_pkg::REARM_DELAY_RST;
            calibrating_reg   <= 1'b0;
            cal_offset_reg    <= '0;
            is_cal_reg        <= 1'b0;
            hold_offset_reg   <= '0;
            blink_mark_reg    <= '0;
            led_reg           <= 1'b0;
            err_glyph_reg     <= idc_pkg::SEG_BLANK;
            inhibit_reg       <= 1'b0;
            rel_timing_reg    <= 1'b0;
            rel_mark_reg      <= '0;
            dig_low_reg       <= idc_pkg::SEG_BLANK;
            dig_high_reg      <= idc_pkg::SEG_BLANK;
            dig_sign_reg      <= idc_pkg::SEG_BLANK;
        end
        else
        begin
            stored_offset_reg <= stored_offset_next;
            stored_valid_reg  <= stored_valid_next;
            blink_period_reg  <= blink_period_next;
            rearm_delay_reg   <= rearm_delay_next;
            calibrating_reg   <= calibrating_next;
            cal_offset_reg    <= cal_offset_next;
            is_cal_reg        <= is_cal_next;
            hold_offset_reg   <= hold_offset_next;
            blink_mark_reg    <= blink_mark_next;
            led_reg           <= led_next;
            err_glyph_reg     <= err_glyph_next;
            inhibit_reg       <= inhibit_next;
            rel_timing_reg    <= rel_timing_next;
            rel_mark_reg      <= rel_mark_next;
            dig_low_reg       <= dig_low_next;
            dig_high_reg      <= dig_high_next;
            dig_sign_reg      <= dig_sign_next;
        end
    end

    always_comb
    begin
        result.seg_low      = dig_low_next;
        result.seg_high     = dig_high_next;
        result.seg_sign     = dig_sign_next;
        result.cal_led      = led_next;
        result.save_strobe  = strobe;
        result.saved_offset = strobe ? item.angle : '0;
    end

endmodule

[rtl/core/inclinometer_display_controller_top.sv]
// Path: an accepted request goes from the input register to the result register,
// which drives the master side. Throughput: one request per cycle while m_tready
// is high; each request makes one pass through the control stage between the two.
// Reset: rst_n is asynchronous and active low; it empties both registers, blanks
// all digits, selects measure mode and loads the configuration defaults.
// Depends on idc_pkg, idc_in_stage, idc_ctrl and idc_digits.

module inclinometer_display_controller_top
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [0] sensor_ok, [16:1] angle, [32:17] now, [33] hold_level,
    // [34] calibrate_level, [39:35] zero
    input  logic [idc_pkg::IN_DAT_W-1:0]       s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [7:0] seg_low, [15:8] seg_high, [23:16] seg_sign, [24] cal_led,
    // [25] save_strobe, [41:26] saved_offset, [47:42] zero
    output logic [idc_pkg::OUT_DAT_W-1:0]      m_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [idc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [idc_pkg::CFG_DAT_W-1:0]      cfg_data
);

    logic           in_valid;
    logic           advance;
    idc_pkg::item_t item;
    idc_pkg::res_t  result;
    idc_pkg::res_t  out_data_reg;
    logic           out_valid_reg;
    logic           out_valid_next;

    assign advance   = in_valid && (!out_valid_reg || m_tready);
    // A register write is taken only in a cycle where no request is processed.
    assign cfg_ready = !advance;

    idc_in_stage u_in_stage
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .advance  (advance),
        .in_valid (in_valid),
        .item     (item)
    );

    idc_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .item      (item),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .result    (result)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = idc_pkg::OUT_DAT_W'(out_data_reg);

endmodule

[rtl/core/idc_checker.sv]
// Port-level checker for the inclinometer display controller, bound to the top.
// Depends on idc_pkg and inclinometer_display_controller_top.

module idc_checker
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tready,
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic [idc_pkg::OUT_DAT_W-1:0]      m_tdata
);

    // A stalled result keeps its payload.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result payload changed while stalled");

    // The input side only stalls behind a result that is waiting.
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result waiting");

    a_sign_glyph: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[23:16] == idc_pkg::SEG_PLUS
                      || m_tdata[23:16] == idc_pkg::SEG_MINUS
                      || m_tdata[23:16] == idc_pkg::SEG_BLANK))
        else $error("sign digit shows an unknown glyph");

    a_saved_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[25] |-> m_tdata[41:26] == '0)
        else $error("saved offset nonzero without save strobe");

    // Completing a calibration turns the LED off in the same request.
    a_led_off_on_save: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[25] |-> !m_tdata[24])
        else $error("calibration LED lit on save request");

endmodule

bind inclinometer_display_controller_top idc_checker u_idc_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
